@@ hdl/apu_fs_pkg.sv @@
// Shared types, constants and the step decoder for the audio frame sequencer.
`default_nettype none

package apu_fs_pkg;

  // Widths of the sequencer state.
  localparam int unsigned DelayWidth = 14;
  localparam int unsigned StepWidth  = 3;
  localparam int unsigned OpWidth    = 2;
  localparam int unsigned DataWidth  = 8;

  // Default number of ticks between sample strobes.
  localparam int unsigned SamplePeriodDef = 40;

  // Delay increments of the step table and the write and reset values.
  localparam logic [DelayWidth-1:0] DlyQuarterA = 14'd7456;
  localparam logic [DelayWidth-1:0] DlyHalf     = 14'd7458;
  localparam logic [DelayWidth-1:0] DlyQuarterB = 14'd7457;
  localparam logic [DelayWidth-1:0] DlyFiveIdle = 14'd7454;
  localparam logic [DelayWidth-1:0] DlyOne      = 14'd1;
  localparam logic [DelayWidth-1:0] DlyWrite    = 14'd7458;
  localparam logic [DelayWidth-1:0] DlyReset    = 14'd7459;

  // Frame register bits.
  localparam int unsigned ModeBit    = 7;
  localparam int unsigned InhibitBit = 6;

  // Item operations.
  typedef enum logic [OpWidth-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Outcome of one sequencer step.
  typedef struct packed {
    logic                  quarter;
    logic                  half;
    logic                  irq;
    logic [DelayWidth-1:0] inc;
    logic [StepWidth-1:0]  next;
  } step_t;

  // Result fields of one item.
  typedef struct packed {
    logic quarter_frame;
    logic half_frame;
    logic irq_request;
    logic sample_strobe;
    logic read_irq_bit;
  } res_t;

  // Decodes one step of the 4-step or 5-step sequence.
  function automatic step_t step_decode(input logic five_step,
                                        input logic [StepWidth-1:0] idx);
    step_t s;
    s.quarter = 1'b0;
    s.half    = 1'b0;
    s.irq     = 1'b0;
    s.inc     = DlyOne;
    s.next    = idx + StepWidth'(1);
    if (!five_step) begin
      case (idx)
        3'd0: begin
          s.quarter = 1'b1;
          s.inc     = DlyQuarterA;
        end
        3'd1: begin
          s.quarter = 1'b1;
          s.half    = 1'b1;
          s.inc     = DlyHalf;
        end
        3'd2: begin
          s.quarter = 1'b1;
          s.inc     = DlyQuarterB;
        end
        3'd3: begin
          s.irq = 1'b1;
        end
        3'd4: begin
          s.quarter = 1'b1;
          s.half    = 1'b1;
          s.irq     = 1'b1;
        end
        3'd5: begin
          s.irq  = 1'b1;
          s.inc  = DlyQuarterB;
          s.next = '0;
        end
        default: begin
          s.next = '0;
        end
      endcase
    end else begin
      case (idx)
        3'd0, 3'd2: begin
          s.quarter = 1'b1;
          s.half    = 1'b1;
          s.inc     = DlyHalf;
        end
        3'd1, 3'd3: begin
          s.quarter = 1'b1;
          s.inc     = DlyQuarterA;
        end
        3'd4: begin
          s.inc  = DlyFiveIdle;
          s.next = '0;
        end
        default: begin
          s.next = '0;
        end
      endcase
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hdl/apu_frame_sequencer_core.sv @@
// An accepted item gives its result through the input register and then the result register.
// Throughput: one item per cycle unless a result is stalled; a stalled result holds while the input register fills.
// Every item gives exactly one result; ticks advance the sequencer, writes reload it.
// Reset (rst_ni low, asynchronous) clears the valid flags of both registers and loads the event delay of 7459.
// The clock is expected to run one tick item per emulated APU cycle.
`default_nettype none

module apu_frame_sequencer_core
  import apu_fs_pkg::*;
#(
  parameter int unsigned SAMPLE_PERIOD = SamplePeriodDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [OpWidth-1:0]   op_i,
  input  wire logic [DataWidth-1:0] write_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      quarter_frame_o,
  output logic                      half_frame_o,
  output logic                      irq_request_o,
  output logic                      sample_strobe_o,
  output logic                      read_irq_bit_o
);

  logic                 in_vld_q;
  logic [OpWidth-1:0]   op_q;
  logic [DataWidth-1:0] data_q;
  logic                 out_vld_q;
  res_t                 res_q;
  res_t                 res;
  logic                 take_in;
  logic                 process;

  // Handshake: the input register moves on whenever the result register can take it.
  assign process    = in_vld_q & ~(out_vld_q & out_stall_i);
  assign in_stall_o = in_vld_q & out_vld_q & out_stall_i;
  assign take_in    = in_valid_i & ~in_stall_o;

  // Sequencer state and item logic.
  apu_fs_core #(
    .SAMPLE_PERIOD(SAMPLE_PERIOD)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (process),
    .op_i  (op_q),
    .data_i(data_q),
    .res_o (res)
  );

  // Valid flags of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take_in) begin
        in_vld_q <= 1'b1;
      end else if (process) begin
        in_vld_q <= 1'b0;
      end
      if (process) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload of the input and result registers.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      op_q   <= op_i;
      data_q <= write_data_i;
    end
    if (process) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign quarter_frame_o = res_q.quarter_frame;
  assign half_frame_o    = res_q.half_frame;
  assign irq_request_o   = res_q.irq_request;
  assign sample_strobe_o = res_q.sample_strobe;
  assign read_irq_bit_o  = res_q.read_irq_bit;

`ifndef SYNTH
  // The input side only stalls while a full input register waits on a blocked result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled without a blocked result");

  // A processed item always shows up as a valid result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process |=> out_vld_q)
    else $error("processed item gave no result");

  // A result that was blocked is still present afterwards.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i && !process) |=> (out_vld_q && $stable(res_q)))
    else $error("blocked result lost or changed");
`endif

endmodule

`default_nettype wire

@@ hdl/apu_fs_core.sv @@
// Sequencer state and the per-item next-state and result logic.
`default_nettype none

module apu_fs_core
  import apu_fs_pkg::*;
#(
  parameter int unsigned SAMPLE_PERIOD = SamplePeriodDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic [OpWidth-1:0]   op_i,
  input  wire logic [DataWidth-1:0] data_i,
  output res_t                      res_o
);

  localparam int unsigned PhaseWidth = (SAMPLE_PERIOD > 1) ? $clog2(SAMPLE_PERIOD) : 1;
  localparam logic [PhaseWidth-1:0] PhaseLast = PhaseWidth'(SAMPLE_PERIOD - 1);

  logic                  mode_q, mode_d;
  logic                  inhibit_q, inhibit_d;
  logic                  flag_q, flag_d;
  logic [StepWidth-1:0]  step_q, step_d;
  logic [DelayWidth-1:0] delay_q, delay_d;
  logic                  parity_q, parity_d;
  logic [PhaseWidth-1:0] phase_q, phase_d;
  logic [DelayWidth-1:0] delay_base;
  step_t                 step;

  // Table lookup for the current step.
  assign step = step_decode(mode_q, step_q);

  // Next state and result of the item at the input.
  always_comb begin
    mode_d     = mode_q;
    inhibit_d  = inhibit_q;
    flag_d     = flag_q;
    step_d     = step_q;
    delay_d    = delay_q;
    parity_d   = parity_q;
    phase_d    = phase_q;
    delay_base = delay_q;
    res_o      = '0;
    unique case (op_i)
      OP_TICK: begin
        res_o.irq_request = flag_q & ~inhibit_q;
        if (delay_q == '0) begin
          res_o.quarter_frame = step.quarter;
          res_o.half_frame    = step.half;
          step_d              = step.next;
          delay_base          = step.inc;
          if (step.irq && !inhibit_q) begin
            flag_d = 1'b1;
          end
        end
        delay_d             = delay_base - DlyOne;
        parity_d            = ~parity_q;
        res_o.sample_strobe = (phase_q == '0);
        phase_d             = (phase_q == PhaseLast) ? '0 : phase_q + PhaseWidth'(1);
      end
      OP_WRITE: begin
        mode_d    = data_i[ModeBit];
        inhibit_d = data_i[InhibitBit];
        if (data_i[InhibitBit]) begin
          flag_d = 1'b0;
        end
        step_d  = '0;
        delay_d = DelayWidth'(parity_q) + DlyOne
                + (data_i[ModeBit] ? '0 : DlyWrite);
      end
      OP_READ: begin
        res_o.read_irq_bit = flag_q;
        flag_d             = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // State registers, advanced once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      inhibit_q <= 1'b0;
      flag_q    <= 1'b0;
      step_q    <= '0;
      delay_q   <= DlyReset;
      parity_q  <= 1'b0;
      phase_q   <= '0;
    end else if (en_i) begin
      mode_q    <= mode_d;
      inhibit_q <= inhibit_d;
      flag_q    <= flag_d;
      step_q    <= step_d;
      delay_q   <= delay_d;
      parity_q  <= parity_d;
      phase_q   <= phase_d;
    end
  end

`ifndef SYNTH
  // The flag can never be set while interrupts are inhibited.
  a_flag_inhibit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inhibit_q |-> !flag_q)
    else $error("frame IRQ flag set while inhibited");

  // The step count stays inside the sequence of the current mode.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q ? (step_q <= 3'd4) : (step_q <= 3'd5)))
    else $error("step index outside the sequence");

  // The delay never goes above the write or reset load.
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delay_q <= DlyWrite + 14'd2)
    else $error("event delay out of range");

  // The sample phase stays below the period.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseLast)
    else $error("sample phase out of range");
`endif

endmodule

`default_nettype wire
